// File: rtl/brbt_pkg.sv
// shared types and constants for the buffer registry with byte total
// no dependencies; used by brbt_ctrl, brbt_dp and the top level in rtl/
`default_nettype none

package brbt_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 256;
    localparam int ADDR_W                = 64;
    localparam int SIZE_W                = 64;
    localparam int TOTAL_W               = 64;
    localparam int STATUS_W              = 3;
    localparam int COUNT_OUT_W           = 9;

    typedef enum logic {
        OP_REGISTER   = 1'b0,
        OP_UNREGISTER = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_NOTFOUND  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_FETCH_LAST,
        S_MOVE_LAST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    latch_req;
        logic    search_start;
        logic    search_run;
        logic    append;
        logic    fetch_last;
        logic    move_last;
        logic    set_status;
        t_status status_code;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_req;
        logic hit;
        logic miss;
        logic full;
        logic is_unreg;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/brbt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module brbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/brbt_ctrl.sv
// request sequencer: check, linear search, append or swap-remove, result
// depends on brbt_pkg
`default_nettype none

module brbt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire brbt_pkg::t_dp_stat i_stat,
    output brbt_pkg::t_dp_cmd      o_cmd
);

    brbt_pkg::t_state r_state;
    brbt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brbt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brbt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = brbt_pkg::S_CHECK;
            end
            brbt_pkg::S_CHECK: begin
                n_state = i_stat.bad_req ? brbt_pkg::S_DONE : brbt_pkg::S_SEARCH;
            end
            brbt_pkg::S_SEARCH: begin
                if (i_stat.hit) begin
                    n_state = i_stat.is_unreg ? brbt_pkg::S_FETCH_LAST : brbt_pkg::S_DONE;
                end else if (i_stat.miss) begin
                    n_state = brbt_pkg::S_DONE;
                end
            end
            brbt_pkg::S_FETCH_LAST: n_state = brbt_pkg::S_MOVE_LAST;
            brbt_pkg::S_MOVE_LAST:  n_state = brbt_pkg::S_DONE;
            brbt_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = brbt_pkg::S_IDLE;
            end
            default: n_state = brbt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            brbt_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.latch_req = i_in_valid;
            end
            brbt_pkg::S_CHECK: begin
                if (i_stat.bad_req) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = brbt_pkg::ST_REJECTED;
                end else begin
                    o_cmd.search_start = 1'b1;
                end
            end
            brbt_pkg::S_SEARCH: begin
                o_cmd.search_run = 1'b1;
                if (i_stat.hit) begin
                    if (!i_stat.is_unreg) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = brbt_pkg::ST_DUPLICATE;
                    end
                end else if (i_stat.miss) begin
                    o_cmd.set_status = 1'b1;
                    if (i_stat.is_unreg) begin
                        o_cmd.status_code = brbt_pkg::ST_NOTFOUND;
                    end else if (i_stat.full) begin
                        o_cmd.status_code = brbt_pkg::ST_FULL;
                    end else begin
                        o_cmd.append      = 1'b1;
                        o_cmd.status_code = brbt_pkg::ST_ADDED;
                    end
                end
            end
            brbt_pkg::S_FETCH_LAST: begin
                o_cmd.fetch_last = 1'b1;
            end
            brbt_pkg::S_MOVE_LAST: begin
                o_cmd.move_last   = 1'b1;
                o_cmd.set_status  = 1'b1;
                o_cmd.status_code = brbt_pkg::ST_REMOVED;
            end
            brbt_pkg::S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/brbt_dp.sv
// datapath: request latch, entry rams, search pointer, count, byte total, result register
// depends on brbt_pkg and brbt_ram
`default_nettype none

module brbt_dp #(
    parameter int TABLE_ENTRIES = brbt_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire brbt_pkg::t_dp_cmd             i_cmd,
    output brbt_pkg::t_dp_stat                 o_stat,
    input  wire logic                          i_opcode,
    input  wire logic [brbt_pkg::ADDR_W-1:0]   i_buffer_address,
    input  wire logic [brbt_pkg::SIZE_W-1:0]   i_buffer_size,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [brbt_pkg::STATUS_W-1:0]      o_status,
    output logic [brbt_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic [brbt_pkg::TOTAL_W-1:0]       o_bytes_used
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    brbt_pkg::t_op                 r_op;
    logic [brbt_pkg::ADDR_W-1:0]   r_addr;
    logic [brbt_pkg::SIZE_W-1:0]   r_size;
    logic [CNT_W-1:0]              r_count;
    logic [brbt_pkg::TOTAL_W-1:0]  r_total;
    logic [CNT_W-1:0]              r_rd_idx;
    logic [IDX_W-1:0]              r_cmp_idx;
    logic                          r_cmp_vld;
    logic [IDX_W-1:0]              r_slot;
    logic [brbt_pkg::SIZE_W-1:0]   r_found_size;
    brbt_pkg::t_status             r_status;
    logic                          r_out_vld;
    brbt_pkg::t_status             r_out_status;
    logic [CNT_W-1:0]              r_out_count;
    logic [brbt_pkg::TOTAL_W-1:0]  r_out_total;

    logic [brbt_pkg::ADDR_W-1:0]   addr_dout;
    logic [brbt_pkg::SIZE_W-1:0]   size_dout;
    logic [CNT_W-1:0]              last_idx;
    logic                          hit;
    logic                          issue;
    logic                          ram_re;
    logic [IDX_W-1:0]              ram_raddr;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [brbt_pkg::ADDR_W-1:0]   ram_waddr_data;
    logic [brbt_pkg::SIZE_W-1:0]   ram_wsize_data;
    logic                          out_free;

    assign last_idx = r_count - CNT_W'(1);
    assign hit      = r_cmp_vld && (addr_dout == r_addr);
    assign issue    = i_cmd.search_run && !hit && (r_rd_idx < r_count);
    assign out_free = !r_out_vld || i_out_ready;

    assign ram_re    = issue || i_cmd.fetch_last;
    assign ram_raddr = i_cmd.fetch_last ? last_idx[IDX_W-1:0] : r_rd_idx[IDX_W-1:0];

    assign ram_we         = i_cmd.append || i_cmd.move_last;
    assign ram_waddr      = i_cmd.append ? r_count[IDX_W-1:0] : r_slot;
    assign ram_waddr_data = i_cmd.append ? r_addr : addr_dout;
    assign ram_wsize_data = i_cmd.append ? r_size : size_dout;

    brbt_ram #(
        .WIDTH (brbt_pkg::ADDR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_waddr_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (addr_dout)
    );

    brbt_ram #(
        .WIDTH (brbt_pkg::SIZE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wsize_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (size_dout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_total   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.search_start) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.search_run) begin
                r_cmp_vld <= issue;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= r_total + r_size;
            end else if (i_cmd.move_last) begin
                r_count <= last_idx;
                r_total <= r_total - r_found_size;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_op   <= brbt_pkg::t_op'(i_opcode);
            r_addr <= i_buffer_address;
            r_size <= i_buffer_size;
        end
        if (i_cmd.search_start) begin
            r_rd_idx <= '0;
        end else if (issue) begin
            r_rd_idx  <= r_rd_idx + CNT_W'(1);
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (i_cmd.search_run && hit) begin
            r_slot       <= r_cmp_idx;
            r_found_size <= size_dout;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_total  <= r_total;
        end
    end

    always_comb begin
        o_stat.bad_req  = (r_addr == '0) ||
                          ((r_op == brbt_pkg::OP_REGISTER) && (r_size == '0));
        o_stat.hit      = hit;
        o_stat.miss     = !r_cmp_vld && (r_rd_idx >= r_count);
        o_stat.full     = r_count >= CNT_W'(TABLE_ENTRIES);
        o_stat.is_unreg = (r_op == brbt_pkg::OP_UNREGISTER);
        o_stat.out_free = out_free;
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_entry_count = brbt_pkg::COUNT_OUT_W'(r_out_count);
    assign o_bytes_used  = r_out_total;

endmodule

`default_nettype wire

// File: rtl/buffer_registry_with_byte_total_core.sv
// top level of the buffer registry with byte total
// depends on brbt_pkg, brbt_ctrl, brbt_dp (and brbt_ram through brbt_dp)
//
// channel   dir  tdata bits                                  tuser bits
// s_axis    in   [63:0] buffer_address, [127:64] buffer_size [0] opcode
// m_axis    out  [8:0] entry_count, [72:9] bytes_used,       [2:0] status
//                [79:73] zero
//
// one transaction at a time; a miss reads every live entry in a linear search with
// one address ram read per cycle; a hit ends the search, and a remove then moves the last
// entry into its slot; a null address, or a zero size on register, is rejected before any search
// no clearing pass after reset; count and total reset to zero
// the next request is taken while a result waits in the output register
// a stalled m_axis holds the result and the request after it waits at its end
`default_nettype none

module buffer_registry_with_byte_total_core #(
    parameter int TABLE_ENTRIES = brbt_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // buffer_address, buffer_size
    input  wire logic [0:0]   s_axis_tuser,  // opcode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [79:0]       m_axis_tdata,  // entry_count, bytes_used, zero pad
    output logic [2:0]        m_axis_tuser   // status
);

    brbt_pkg::t_dp_cmd  cmd;
    brbt_pkg::t_dp_stat stat;

    logic [brbt_pkg::STATUS_W-1:0]    status;
    logic [brbt_pkg::COUNT_OUT_W-1:0] entry_count;
    logic [brbt_pkg::TOTAL_W-1:0]     bytes_used;

    brbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    brbt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (s_axis_tuser[0]),
        .i_buffer_address (s_axis_tdata[63:0]),
        .i_buffer_size    (s_axis_tdata[127:64]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_status         (status),
        .o_entry_count    (entry_count),
        .o_bytes_used     (bytes_used)
    );

    assign m_axis_tdata = {7'd0, bytes_used, entry_count};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

// File: bench/buffer_registry_with_byte_total_core_test.sv
// self-checking bench for buffer_registry_with_byte_total_core: directed and random register and
// unregister requests, with results checked against a behavioral registry model
// depends on brbt_pkg and the rtl/ sources
`timescale 1ns / 100ps

module buffer_registry_with_byte_total_core_test;
    import brbt_pkg::*;

    localparam int SLOTS = DEFAULT_TABLE_ENTRIES;

    typedef struct {
        t_op         op;
        logic [63:0] addr;
        logic [63:0] size;
    } t_request;

    typedef struct {
        t_status     status;
        logic [8:0]  count;
        logic [63:0] bytes;
    } t_reply;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // buffer_address, buffer_size
    logic [0:0]   s_axis_tuser = '0;   // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;        // entry_count, bytes_used, zero pad
    logic [2:0]   m_axis_tuser;        // status

    buffer_registry_with_byte_total_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // request stream and the generator's view of the live addresses
    t_request    pending_reqs[$];
    logic [63:0] planned_live[$];
    logic [63:0] planned_gone[$];

    // registry model
    logic [63:0] registry_addr[SLOTS];
    logic [63:0] registry_size[SLOTS];
    int unsigned registry_count = 0;
    logic [63:0] registry_bytes = '0;
    t_reply      expected_replies[$];

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    bit   send_calm = 1'b0;
    bit   recv_calm = 1'b0;
    int   reqs_taken = 0;
    int   replies_checked = 0;
    int   mismatches = 0;
    int   status_seen[6] = '{default: 0};
    int   peak_count = 0;

    function automatic logic [63:0] any64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_addr();
        logic [63:0] a;
        a = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(1, 4096)) : any64();
        return (a == 0) ? 64'd1 : a;
    endfunction

    function automatic logic [63:0] rand_size();
        logic [63:0] s;
        case ($urandom_range(0, 7))
            0, 1:    s = 64'($urandom_range(1, 4096));
            2:       s = {32'hFFFF_FFFF, $urandom};
            default: s = any64();
        endcase
        return (s == 0) ? 64'd1 : s;
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic queue_request(input t_op op, input logic [63:0] addr,
                                 input logic [63:0] size);
        t_request req;
        int hit;
        req.op = op;
        req.addr = addr;
        req.size = size;
        pending_reqs.push_back(req);
        hit = -1;
        foreach (planned_live[k])
            if (planned_live[k] == addr) hit = k;
        if (op == OP_REGISTER) begin
            if (addr != 0 && size != 0 && hit < 0 && planned_live.size() < SLOTS)
                planned_live.push_back(addr);
        end else if (hit >= 0) begin
            planned_live.delete(hit);
            planned_gone.push_back(addr);
        end
    endtask

    task automatic queue_noise();
        case ($urandom_range(0, 5))
            0: queue_request(OP_REGISTER, 64'd0, rand_size());
            1: queue_request(OP_REGISTER, rand_addr(), 64'd0);
            2: queue_request(OP_UNREGISTER, 64'd0, any64());
            3: begin
                if (planned_live.size() > 0)
                    queue_request(OP_REGISTER,
                        planned_live[$urandom_range(0, planned_live.size() - 1)], rand_size());
                else
                    queue_request(OP_REGISTER, 64'd0, 64'd0);
            end
            4: begin
                if (planned_gone.size() > 0 && $urandom_range(0, 1))
                    queue_request(OP_UNREGISTER,
                        planned_gone[$urandom_range(0, planned_gone.size() - 1)], any64());
                else
                    queue_request(OP_UNREGISTER, rand_addr(), any64());
            end
            default: queue_request(OP_REGISTER, 64'd0, 64'd0);
        endcase
    endtask

    task automatic queue_unregister_live();
        if (planned_live.size() > 0)
            queue_request(OP_UNREGISTER,
                planned_live[$urandom_range(0, planned_live.size() - 1)], any64());
        else
            queue_noise();
    endtask

    task automatic apply_to_registry(input t_op op, input logic [63:0] addr,
                                     input logic [63:0] size);
        t_reply res;
        int unsigned slot;
        slot = registry_count;
        for (int unsigned k = 0; k < registry_count; k++)
            if (registry_addr[k] == addr && slot == registry_count) slot = k;
        if (op == OP_REGISTER) begin
            if (addr == 0 || size == 0) begin
                res.status = ST_REJECTED;
            end else if (slot < registry_count) begin
                res.status = ST_DUPLICATE;
            end else if (registry_count >= SLOTS) begin
                res.status = ST_FULL;
            end else begin
                registry_addr[registry_count] = addr;
                registry_size[registry_count] = size;
                registry_count++;
                registry_bytes += size;
                res.status = ST_ADDED;
            end
        end else if (addr == 0) begin
            res.status = ST_REJECTED;
        end else if (slot < registry_count) begin
            // last entry fills the hole
            registry_bytes -= registry_size[slot];
            registry_addr[slot] = registry_addr[registry_count - 1];
            registry_size[slot] = registry_size[registry_count - 1];
            registry_count--;
            res.status = ST_REMOVED;
        end else begin
            res.status = ST_NOTFOUND;
        end
        res.count = 9'(registry_count);
        res.bytes = registry_bytes;
        if (registry_count > peak_count) peak_count = registry_count;
        expected_replies.push_back(res);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin : drive_requests
        t_request req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0 || pending_reqs.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {req.size, req.addr};
                s_axis_tuser <= req.op;
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                send_gap <= draw_gap(send_calm);
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin : drive_ready
        int gap;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else if (out_fire) begin
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            gap = draw_gap(recv_calm);
            recv_gap <= gap;
            m_axis_tready <= (gap == 0);
        end else if (!m_axis_tready) begin
            if (recv_gap <= 1) begin
                m_axis_tready <= 1'b1;
                recv_gap <= 0;
            end else begin
                recv_gap <= recv_gap - 1;
            end
        end
    end

    // transaction monitor and checker
    always @(posedge i_clk) begin : monitor
        t_reply want;
        in_fire <= s_axis_tvalid && s_axis_tready;
        out_fire <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            apply_to_registry(t_op'(s_axis_tuser[0]), s_axis_tdata[63:0], s_axis_tdata[127:64]);
            reqs_taken++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d", $time,
                         m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                check_field("status", 64'(want.status), 64'(m_axis_tuser));
                check_field("entry_count", 64'(want.count), 64'(m_axis_tdata[8:0]));
                check_field("bytes_used", want.bytes, m_axis_tdata[72:9]);
                check_field("pad", 64'd0, 64'(m_axis_tdata[79:73]));
                status_seen[want.status]++;
                replies_checked++;
            end
        end
    end

    initial begin : run
        int total_reqs;
        int pick;

        // empty table, null and zero cases, wrap of the total, swap on removal
        queue_request(OP_UNREGISTER, 64'h1234, 64'h1);
        queue_request(OP_REGISTER, 64'd0, 64'h10);
        queue_request(OP_REGISTER, 64'h1000, 64'd0);
        queue_request(OP_REGISTER, 64'd0, 64'd0);
        queue_request(OP_UNREGISTER, 64'd0, 64'd0);
        queue_request(OP_REGISTER, '1, '1);
        queue_request(OP_REGISTER, 64'd1, 64'd2);
        queue_request(OP_REGISTER, '1, 64'd5);
        queue_request(OP_REGISTER, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        queue_request(OP_UNREGISTER, '1, 64'd0);
        queue_request(OP_UNREGISTER, '1, 64'd0);
        queue_request(OP_UNREGISTER, 64'd1, '1);
        queue_request(OP_UNREGISTER, 64'h8000_0000_0000_0000, 64'd0);
        queue_request(OP_UNREGISTER, 64'h8000_0000_0000_0000, 64'd0);
        queue_request(OP_REGISTER, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(OP_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_request(OP_UNREGISTER, 64'h5555_5555_5555_5555, '1);
        queue_request(OP_UNREGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0);

        // fill past capacity
        for (int n = 0; n < 340; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 93) queue_request(OP_REGISTER, rand_addr(), rand_size());
            else if (pick < 96) queue_unregister_live();
            else queue_noise();
        end
        // churn near full
        for (int n = 0; n < 600; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) queue_request(OP_REGISTER, rand_addr(), rand_size());
            else if (pick < 85) queue_unregister_live();
            else queue_noise();
        end
        // drain to empty
        for (int n = 0; n < 440; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) queue_unregister_live();
            else if (pick < 90) queue_request(OP_REGISTER, rand_addr(), rand_size());
            else queue_noise();
        end
        total_reqs = pending_reqs.size();

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_taken < total_reqs || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("%0d results checked: %0d added, %0d rejected, %0d duplicate, %0d full, %0d removed, %0d not found",
                 replies_checked, status_seen[ST_ADDED], status_seen[ST_REJECTED],
                 status_seen[ST_DUPLICATE], status_seen[ST_FULL], status_seen[ST_REMOVED],
                 status_seen[ST_NOTFOUND]);
        $display("peak table occupancy %0d of %0d entries", peak_count, SLOTS);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
